[rtl/nibble_handshake_sensor_slave_unit_defines.svh]
// assertion macros shared by the nibble handshake sensor slave rtl
`ifndef NIBBLE_HANDSHAKE_SENSOR_SLAVE_UNIT_DEFINES_SVH
`define NIBBLE_HANDSHAKE_SENSOR_SLAVE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NHSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define NHSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nhss_pkg.sv]
// shared types, constants and helpers for the nibble handshake sensor slave
`default_nettype none

package nhss_pkg;

    // nibble masks and the released level of the data lines
    localparam logic [7:0] NIB_LO       = 8'h0F;
    localparam logic [7:0] NIB_HI       = 8'hF0;
    localparam logic [3:0] NIB_RELEASED = 4'hF;

    // handshake phases, one-hot
    typedef enum logic [8:0] {
        PH_WAIT_IDLE = 9'b000000001,
        PH_WAIT_ATT  = 9'b000000010,
        PH_LIGHT_LO  = 9'b000000100,
        PH_LIGHT_HI  = 9'b000001000,
        PH_TEMP_LO   = 9'b000010000,
        PH_TEMP_HI   = 9'b000100000,
        PH_SOUND_LO  = 9'b001000000,
        PH_SOUND_HI  = 9'b010000000,
        PH_WAIT_DROP = 9'b100000000
    } t_phase;

    // one sample of the pins and sensors
    typedef struct packed {
        logic       attention;
        logic       strobe_req;
        logic       line_six_in;
        logic [7:0] light_value;
        logic [7:0] temperature_value;
        logic [7:0] sound_value;
    } t_in_item;

    // pin drives and phase after one sample
    typedef struct packed {
        logic [3:0] data_nibble;
        logic       ack_drive_low;
        logic       port_zero_out;
        logic       port_one_out;
        logic [3:0] phase_now;
    } t_result;

    // phase number reported to the user
    function automatic logic [3:0] phase_number(input t_phase ph);
        logic [3:0] num;
        case (ph)
            PH_WAIT_IDLE: num = 4'd0;
            PH_WAIT_ATT:  num = 4'd1;
            PH_LIGHT_LO:  num = 4'd2;
            PH_LIGHT_HI:  num = 4'd3;
            PH_TEMP_LO:   num = 4'd4;
            PH_TEMP_HI:   num = 4'd5;
            PH_SOUND_LO:  num = 4'd6;
            PH_SOUND_HI:  num = 4'd7;
            PH_WAIT_DROP: num = 4'd8;
            default:      num = 4'd0;
        endcase
        return num;
    endfunction

    // upper nibble of a sensor byte
    function automatic logic [3:0] high_nibble(input logic [7:0] v);
        logic [7:0] sh;
        sh = (v & NIB_HI) >> 4;
        return sh[3:0];
    endfunction

    // lower nibble of a sensor byte
    function automatic logic [3:0] low_nibble(input logic [7:0] v);
        logic [7:0] m;
        m = v & NIB_LO;
        return m[3:0];
    endfunction

endpackage

`default_nettype wire

[rtl/nhss_core.sv]
// handshake state machine: advances one step per accepted sample
`default_nettype none
`include "nibble_handshake_sensor_slave_unit_defines.svh"

module nhss_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire nhss_pkg::t_in_item i_item,
    output nhss_pkg::t_result     o_result
);

    nhss_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_light, n_light;
    logic [7:0] r_temp, n_temp;
    logic [7:0] r_sound, n_sound;
    logic       r_pend_zero, n_pend_zero;
    logic       r_pend_one, n_pend_one;
    logic       r_port_zero, n_port_zero;
    logic       r_port_one, n_port_one;
    logic [3:0] r_nibble, n_nibble;
    logic       r_ack_low, n_ack_low;

    // next state for one sample
    always_comb begin
        n_phase     = r_phase;
        n_light     = r_light;
        n_temp      = r_temp;
        n_sound     = r_sound;
        n_pend_zero = r_pend_zero;
        n_pend_one  = r_pend_one;
        n_port_zero = r_port_zero;
        n_port_one  = r_port_one;
        n_nibble    = r_nibble;
        n_ack_low   = r_ack_low;
        case (r_phase)
            nhss_pkg::PH_WAIT_ATT: begin
                if (i_item.attention) begin
                    n_light   = i_item.light_value;
                    n_temp    = i_item.temperature_value;
                    n_sound   = i_item.sound_value;
                    n_ack_low = 1'b1;
                    n_phase   = nhss_pkg::PH_LIGHT_LO;
                end
            end
            nhss_pkg::PH_LIGHT_LO, nhss_pkg::PH_TEMP_LO, nhss_pkg::PH_SOUND_LO: begin
                if (!i_item.strobe_req) begin
                    if (r_phase == nhss_pkg::PH_LIGHT_LO) begin
                        n_nibble  = nhss_pkg::low_nibble(r_light);
                        n_ack_low = 1'b0;
                        n_phase   = nhss_pkg::PH_LIGHT_HI;
                    end else if (r_phase == nhss_pkg::PH_TEMP_LO) begin
                        n_nibble    = nhss_pkg::low_nibble(r_temp);
                        n_pend_zero = i_item.line_six_in;
                        n_phase     = nhss_pkg::PH_TEMP_HI;
                    end else begin
                        n_nibble   = nhss_pkg::low_nibble(r_sound);
                        n_pend_one = i_item.line_six_in;
                        n_phase    = nhss_pkg::PH_SOUND_HI;
                    end
                end else if (!i_item.attention) begin
                    // abort: release lines, keep port outputs
                    n_nibble  = nhss_pkg::NIB_RELEASED;
                    n_ack_low = 1'b0;
                    n_phase   = nhss_pkg::PH_WAIT_ATT;
                end
            end
            nhss_pkg::PH_LIGHT_HI, nhss_pkg::PH_TEMP_HI, nhss_pkg::PH_SOUND_HI: begin
                if (i_item.strobe_req) begin
                    if (r_phase == nhss_pkg::PH_LIGHT_HI) begin
                        n_nibble = nhss_pkg::high_nibble(r_light);
                        n_phase  = nhss_pkg::PH_TEMP_LO;
                    end else if (r_phase == nhss_pkg::PH_TEMP_HI) begin
                        n_nibble = nhss_pkg::high_nibble(r_temp);
                        n_phase  = nhss_pkg::PH_SOUND_LO;
                    end else begin
                        n_nibble = nhss_pkg::high_nibble(r_sound);
                        n_phase  = nhss_pkg::PH_WAIT_DROP;
                    end
                end else if (!i_item.attention) begin
                    n_nibble  = nhss_pkg::NIB_RELEASED;
                    n_ack_low = 1'b0;
                    n_phase   = nhss_pkg::PH_WAIT_ATT;
                end
            end
            nhss_pkg::PH_WAIT_DROP: begin
                if (!i_item.attention) begin
                    n_port_zero = r_pend_zero;
                    n_port_one  = r_pend_one;
                    n_nibble    = nhss_pkg::NIB_RELEASED;
                    n_ack_low   = 1'b0;
                    n_phase     = nhss_pkg::PH_WAIT_ATT;
                end
            end
            default: begin
                // after reset: wait for attention inactive
                n_phase = i_item.attention ? nhss_pkg::PH_WAIT_IDLE : nhss_pkg::PH_WAIT_ATT;
            end
        endcase
    end

    // state registers, advanced on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= nhss_pkg::PH_WAIT_IDLE;
            r_light     <= 8'h00;
            r_temp      <= 8'h00;
            r_sound     <= 8'h00;
            r_pend_zero <= 1'b0;
            r_pend_one  <= 1'b0;
            r_port_zero <= 1'b0;
            r_port_one  <= 1'b0;
            r_nibble    <= nhss_pkg::NIB_RELEASED;
            r_ack_low   <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_light     <= n_light;
            r_temp      <= n_temp;
            r_sound     <= n_sound;
            r_pend_zero <= n_pend_zero;
            r_pend_one  <= n_pend_one;
            r_port_zero <= n_port_zero;
            r_port_one  <= n_port_one;
            r_nibble    <= n_nibble;
            r_ack_low   <= n_ack_low;
        end
    end

    // result of this step, from the post-step state
    always_comb begin
        o_result.data_nibble   = n_nibble;
        o_result.ack_drive_low = n_ack_low;
        o_result.port_zero_out = n_port_zero;
        o_result.port_one_out  = n_port_one;
        o_result.phase_now     = nhss_pkg::phase_number(n_phase);
    end

    // acknowledge is held low only between capture and the first nibble
    `NHSS_ASSERT_NOW(a_ack_only_first, r_ack_low, r_phase == nhss_pkg::PH_LIGHT_LO, "ack low outside first phase")
    // data lines released whenever no transfer runs
    `NHSS_ASSERT_NOW(a_idle_released, (r_phase == nhss_pkg::PH_WAIT_IDLE) || (r_phase == nhss_pkg::PH_WAIT_ATT), r_nibble == nhss_pkg::NIB_RELEASED, "data lines driven while idle")
    // port outputs only move at the end of a full transfer
    `NHSS_ASSERT_NEXT(a_port_hold, !(i_accept && (r_phase == nhss_pkg::PH_WAIT_DROP)), $stable(r_port_zero) && $stable(r_port_one), "port output changed outside transfer end")

endmodule

`default_nettype wire

[rtl/nibble_handshake_sensor_slave_unit.sv]
// top level: stream ports, handshake core and two-entry result buffer
// Each input transaction is one sample of the pins and sensors and yields exactly one
// result transaction; an item is accepted every cycle while s_axis_tready is high.
// The handshake core advances its state machine in the cycle of acceptance; the
// result goes into an output register backed by one skid entry, so intake goes on
// for one more item while the output side stalls, and s_axis_tready drops only while
// the skid entry is full. No reset sweep; ready right after reset.
`default_nettype none
`include "nibble_handshake_sensor_slave_unit_defines.svh"

module nibble_handshake_sensor_slave_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // attention, strobe_req, line_six_in, light_value[7:0],
    // temperature_value[7:0], sound_value[7:0], zero fill
    input  wire logic [31:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // data_nibble[3:0], ack_drive_low, port_zero_out, port_one_out,
    // phase_now[3:0], zero fill
    output logic [15:0]      o_m_axis_tdata
);

    nhss_pkg::t_in_item in_item;
    nhss_pkg::t_result  step_result;
    logic               in_accept;
    logic               out_fire;

    nhss_pkg::t_result  r_out, r_skid;
    logic               r_out_valid, r_skid_valid;

    // unpack the input transaction
    always_comb begin
        in_item.attention         = i_s_axis_tdata[0];
        in_item.strobe_req        = i_s_axis_tdata[1];
        in_item.line_six_in       = i_s_axis_tdata[2];
        in_item.light_value       = i_s_axis_tdata[10:3];
        in_item.temperature_value = i_s_axis_tdata[18:11];
        in_item.sound_value       = i_s_axis_tdata[26:19];
    end

    assign o_s_axis_tready = !r_skid_valid;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire        = r_out_valid && i_m_axis_tready;

    nhss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (in_item),
        .o_result (step_result)
    );

    // result buffer valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire && r_skid_valid) begin
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end else if (in_accept) begin
            if (!r_out_valid || out_fire) begin
                r_out <= step_result;
            end else begin
                r_skid <= step_result;
            end
        end
    end

    // pack the output transaction
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b00000, r_out.phase_now, r_out.port_one_out,
                              r_out.port_zero_out, r_out.ack_drive_low, r_out.data_nibble};

    // skid entry never holds data ahead of an empty output register
    `NHSS_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    // an accepted item into an empty buffer is offered next cycle
    `NHSS_ASSERT_NEXT(a_result_offered, in_accept && !r_out_valid, r_out_valid && !r_skid_valid, "accepted item not offered")
    // draining the output moves the skid entry forward
    `NHSS_ASSERT_NEXT(a_skid_drains, r_skid_valid && out_fire, !r_skid_valid && r_out_valid, "skid entry not drained")

endmodule

`default_nettype wire

[dv/tb.sv]
// testbench for the nibble handshake sensor slave: directed and random pin samples
`timescale 1ns / 100ps

module tb;

    // protocol phase numbers as reported on the result stream
    localparam logic [3:0] ST_IDLE_WAIT = 4'd0;
    localparam logic [3:0] ST_ATT_WAIT  = 4'd1;
    localparam logic [3:0] ST_LIGHT_LO  = 4'd2;
    localparam logic [3:0] ST_LIGHT_HI  = 4'd3;
    localparam logic [3:0] ST_TEMP_LO   = 4'd4;
    localparam logic [3:0] ST_TEMP_HI   = 4'd5;
    localparam logic [3:0] ST_SOUND_LO  = 4'd6;
    localparam logic [3:0] ST_SOUND_HI  = 4'd7;
    localparam logic [3:0] ST_DROP_WAIT = 4'd8;

    localparam int ITEMS_TARGET = 1250;
    localparam int STALL_LIMIT  = 1000;
    localparam int REPORT_MAX   = 10;

    // one sample of the pins and sensors
    typedef struct packed {
        logic       attention;
        logic       strobe;
        logic       six;
        logic [7:0] light;
        logic [7:0] temp;
        logic [7:0] sound;
    } t_sample;

    // pin drives and phase after one sample
    typedef struct packed {
        logic [3:0] nibble;
        logic       ack_low;
        logic       port_zero;
        logic       port_one;
        logic [3:0] phase;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // attention, strobe_req, line_six_in, light_value[7:0],
    // temperature_value[7:0], sound_value[7:0], zero fill
    logic [31:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // data_nibble[3:0], ack_drive_low, port_zero_out, port_one_out,
    // phase_now[3:0], zero fill
    logic [15:0] o_m_axis_tdata;

    // handshake state kept by the predictor
    logic [3:0] hs_phase = ST_IDLE_WAIT;
    logic [7:0] light_hold = '0;
    logic [7:0] temp_hold = '0;
    logic [7:0] sound_hold = '0;
    logic       pend_port_zero = 1'b0;
    logic       pend_port_one = 1'b0;
    logic       port_zero_q = 1'b0;
    logic       port_one_q = 1'b0;
    logic [3:0] nibble_q = nhss_pkg::NIB_RELEASED;
    logic       ack_low_q = 1'b0;

    t_reading expected_readings[$];
    int       items_sent = 0;
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       steady = 1'b0;

    nibble_handshake_sensor_slave_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // random back-pressure on the result side
    always @(negedge i_clk) begin
        i_m_axis_tready = steady || ($urandom_range(0, 99) >= 18);
    end

    // advance the predicted handshake by one pin sample
    task automatic advance_handshake(input t_sample smp, output t_reading rd);
        case (hs_phase)
            ST_ATT_WAIT: begin
                if (smp.attention) begin
                    light_hold = smp.light;
                    temp_hold  = smp.temp;
                    sound_hold = smp.sound;
                    ack_low_q  = 1'b1;
                    hs_phase   = ST_LIGHT_LO;
                end
            end
            ST_LIGHT_LO, ST_TEMP_LO, ST_SOUND_LO: begin
                if (!smp.strobe) begin
                    if (hs_phase == ST_LIGHT_LO) begin
                        nibble_q  = light_hold[3:0];
                        ack_low_q = 1'b0;
                    end else if (hs_phase == ST_TEMP_LO) begin
                        nibble_q       = temp_hold[3:0];
                        pend_port_zero = smp.six;
                    end else begin
                        nibble_q      = sound_hold[3:0];
                        pend_port_one = smp.six;
                    end
                    hs_phase = hs_phase + 4'd1;
                end else if (!smp.attention) begin
                    nibble_q  = nhss_pkg::NIB_RELEASED;
                    ack_low_q = 1'b0;
                    hs_phase  = ST_ATT_WAIT;
                end
            end
            ST_LIGHT_HI, ST_TEMP_HI, ST_SOUND_HI: begin
                if (smp.strobe) begin
                    if (hs_phase == ST_LIGHT_HI) begin
                        nibble_q = light_hold[7:4];
                    end else if (hs_phase == ST_TEMP_HI) begin
                        nibble_q = temp_hold[7:4];
                    end else begin
                        nibble_q = sound_hold[7:4];
                    end
                    hs_phase = hs_phase + 4'd1;
                end else if (!smp.attention) begin
                    nibble_q  = nhss_pkg::NIB_RELEASED;
                    ack_low_q = 1'b0;
                    hs_phase  = ST_ATT_WAIT;
                end
            end
            ST_DROP_WAIT: begin
                if (!smp.attention) begin
                    port_zero_q = pend_port_zero;
                    port_one_q  = pend_port_one;
                    nibble_q    = nhss_pkg::NIB_RELEASED;
                    ack_low_q   = 1'b0;
                    hs_phase    = ST_ATT_WAIT;
                end
            end
            default: begin
                hs_phase = smp.attention ? ST_IDLE_WAIT : ST_ATT_WAIT;
            end
        endcase
        rd.nibble    = nibble_q;
        rd.ack_low   = ack_low_q;
        rd.port_zero = port_zero_q;
        rd.port_one  = port_one_q;
        rd.phase     = hs_phase;
    endtask

    // send one pin sample, predict its reading once the transaction is taken
    task automatic send_sample(input logic att, input logic strobe, input logic six,
                               input logic [7:0] light, input logic [7:0] temp,
                               input logic [7:0] sound);
        t_sample  smp;
        t_reading rd;
        int       gap;
        smp.attention = att;
        smp.strobe    = strobe;
        smp.six       = six;
        smp.light     = light;
        smp.temp      = temp;
        smp.sound     = sound;
        @(negedge i_clk);
        if (!steady && $urandom_range(0, 99) < 9) begin
            i_s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  = {5'b0, sound, temp, light, six, strobe, att};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        advance_handshake(smp, rd);
        expected_readings.push_back(rd);
        items_sent++;
    endtask

    // sample with random strobe, six and sensor bytes
    task automatic send_noise(input logic att);
        send_sample(att, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // attention held high before it was ever low, then released
    task automatic test_startup();
        send_sample(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        send_sample(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
        send_sample(1'b0, 1'b1, 1'b0, 8'h3C, 8'hC3, 8'h99);
    endtask

    // complete transfer with extreme sensor values, wait steps and both port bits set
    task automatic test_full_transfer();
        // capture with strobe already low: the edge counts only from the next sample
        send_sample(1'b1, 1'b0, 1'b0, 8'hFF, 8'h00, 8'hA5);
        send_sample(1'b1, 1'b0, 1'b0, 8'h00, 8'hFF, 8'h00);
        send_sample(1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00);
        send_sample(1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
        send_sample(1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00);
        send_sample(1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
        send_sample(1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00);
        send_sample(1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
        send_sample(1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
        send_sample(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    endtask

    // aborts, and an edge taken in the same sample as attention dropping
    task automatic test_abort();
        send_sample(1'b1, 1'b1, 1'b0, 8'h00, 8'hFF, 8'h5A);
        send_sample(1'b0, 1'b1, 1'b0, 8'hFF, 8'h00, 8'hFF);
        send_sample(1'b1, 1'b1, 1'b1, 8'h81, 8'h7E, 8'h18);
        send_sample(1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00);
        send_sample(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
    endtask

    // one well-formed transfer with random content, optional waits and aborts
    task automatic random_transfer();
        logic lvl;
        repeat ($urandom_range(0, 2)) send_noise(1'b0);
        send_noise(1'b1);
        for (int e = 0; e < 6; e++) begin
            // even steps wait for strobe low, odd steps for strobe high
            lvl = (e % 2) != 0;
            repeat ($urandom_range(0, 2))
                send_sample(1'b1, !lvl, 1'($urandom_range(0, 1)),
                            8'($urandom), 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 99) < 4) begin
                send_sample(1'b0, !lvl, 1'($urandom_range(0, 1)),
                            8'($urandom), 8'($urandom), 8'($urandom));
                return;
            end
            send_sample(1'($urandom_range(0, 99) >= 5), lvl, 1'($urandom_range(0, 1)),
                        8'($urandom), 8'($urandom), 8'($urandom));
        end
        repeat ($urandom_range(0, 2)) send_noise(1'b1);
        send_noise(1'b0);
    endtask

    // mostly well-formed transfers, some raw noise, a stretch without idling
    task automatic test_random();
        while (items_sent < ITEMS_TARGET) begin
            steady = (items_sent >= 500) && (items_sent < 800);
            if ($urandom_range(0, 99) < 80) begin
                random_transfer();
            end else begin
                repeat ($urandom_range(1, 8)) send_noise(1'($urandom_range(0, 1)));
            end
        end
        steady = 1'b0;
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_reading got;
        t_reading want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            // unpack fields from the lowest bit up
            got.nibble    = o_m_axis_tdata[3:0];
            got.ack_low   = o_m_axis_tdata[4];
            got.port_zero = o_m_axis_tdata[5];
            got.port_one  = o_m_axis_tdata[6];
            got.phase     = o_m_axis_tdata[10:7];
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result transaction %h", got);
            end else begin
                want = expected_readings.pop_front();
                if (got.nibble !== want.nibble || got.ack_low !== want.ack_low ||
                    got.port_zero !== want.port_zero || got.port_one !== want.port_one ||
                    got.phase !== want.phase) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"result error: nibble %h/%h ack %b/%b p0 %b/%b ",
                                  "p1 %b/%b phase %0d/%0d (expected/actual)"},
                                 want.nibble, got.nibble, want.ack_low, got.ack_low,
                                 want.port_zero, got.port_zero, want.port_one,
                                 got.port_one, want.phase, got.phase);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("nibble_handshake_sensor_slave_unit: mismatch");
            $finish;
        end
    end

    // reset, tests in turn, drain and verdict
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_startup();
        test_full_transfer();
        test_abort();
        test_random();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("nibble_handshake_sensor_slave_unit: match");
        end else begin
            $display("nibble_handshake_sensor_slave_unit: mismatch");
        end
        $finish;
    end

endmodule
